[hw/rtl/oaht_pkg.sv]
// Package for the open addressing hash table core.
// Holds payload structs, command/status codes and state enums.
// No dependencies.
package oaht_pkg;

  localparam int unsigned SIZE_W = 11;  // width of table_size and of slot/probe counters
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned KEY_W  = 64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_length;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [9:0] slot_index;
    logic [9:0] probe_count;
  } out_t;

  // Classified command handed from front to back
  typedef struct packed {
    cmd_e              cmd;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [SIZE_W-1:0] home;
  } qent_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_EMIT
  } back_state_e;

endpackage

[hw/rtl/oaht_front.sv]
// Front part: accepts commands, clamps and masks the key, computes the home slot.
// Hashing runs one bit a cycle with a compare-subtract modulo. Uses oaht_pkg.
module oaht_front #(
  parameter int unsigned KEY_CHARS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  oaht_pkg::in_t                in_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [oaht_pkg::SIZE_W-1:0]  size_i,
  output oaht_pkg::qent_t              enq_data_o,
  output logic                         enq_o,
  input  logic                         q_full_i
);

  oaht_pkg::front_state_e state_q, state_d;
  oaht_pkg::qent_t        ent_q, ent_d;
  logic [oaht_pkg::SIZE_W-1:0] h_q, h_d;
  logic [3:0]             byte_q, byte_d;
  logic [2:0]             phase_q, phase_d;

  logic                   accept;
  logic [oaht_pkg::LEN_W-1:0] len_c;
  logic [oaht_pkg::KEY_W-1:0] key_c;
  logic [7:0]             cur_byte;
  logic [oaht_pkg::SIZE_W:0] t_sum;
  logic [oaht_pkg::SIZE_W-1:0] t_rem;

  assign accept = push_i && !full_o;

  always_comb begin
    len_c = in_i.key_length;
    if (in_i.key_length > oaht_pkg::LEN_W'(KEY_CHARS)) begin
      len_c = oaht_pkg::LEN_W'(KEY_CHARS);
    end
    for (int k = 0; k < 8; k++) begin
      key_c[k*8 +: 8] = (oaht_pkg::LEN_W'(k) < len_c) ? in_i.key_bytes[k*8 +: 8] : 8'h00;
    end
  end

  // (128*h + b) mod size: add the top bit, then double in the remaining seven
  always_comb begin
    cur_byte = ent_q.key[{byte_q[2:0], 3'b000} +: 8];
    if (phase_q == 3'd0) begin
      t_sum = {1'b0, h_q} + {{oaht_pkg::SIZE_W{1'b0}}, cur_byte[7]};
    end else begin
      t_sum = {h_q, cur_byte[~phase_q]};
    end
    if (t_sum >= {1'b0, size_i}) begin
      t_sum = t_sum - {1'b0, size_i};
    end
    t_rem = t_sum[oaht_pkg::SIZE_W-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    h_d     = h_q;
    byte_d  = byte_q;
    phase_d = phase_q;
    case (state_q)
      oaht_pkg::F_IDLE: begin
        if (accept) begin
          ent_d.cmd  = oaht_pkg::cmd_e'(in_i.cmd);
          ent_d.key  = key_c;
          ent_d.len  = len_c;
          ent_d.home = '0;
          h_d        = '0;
          byte_d     = '0;
          phase_d    = '0;
          if (oaht_pkg::cmd_e'(in_i.cmd) == oaht_pkg::CMD_NOP) begin
            state_d = oaht_pkg::F_IDLE;
          end else if (oaht_pkg::cmd_e'(in_i.cmd) == oaht_pkg::CMD_CLEAR || len_c == '0) begin
            state_d = oaht_pkg::F_PUSH;
          end else begin
            state_d = oaht_pkg::F_HASH;
          end
        end
      end
      oaht_pkg::F_HASH: begin
        h_d     = t_rem;
        phase_d = phase_q + 3'd1;
        if (phase_q == 3'd7) begin
          byte_d = byte_q + 4'd1;
          if (byte_q + 4'd1 == ent_q.len) begin
            ent_d.home = t_rem;
            state_d    = oaht_pkg::F_PUSH;
          end
        end
      end
      oaht_pkg::F_PUSH: begin
        if (!q_full_i) begin
          state_d = oaht_pkg::F_IDLE;
        end
      end
      default: state_d = oaht_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full_o     = (state_q != oaht_pkg::F_IDLE);
    enq_o      = (state_q == oaht_pkg::F_PUSH) && !q_full_i;
    enq_data_o = ent_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oaht_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    h_q     <= h_d;
    byte_q  <= byte_d;
    phase_q <= phase_d;
  end

  a_hash_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == oaht_pkg::F_HASH |-> h_q < size_i)
    else $error("hash remainder out of range");
  a_hash_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == oaht_pkg::F_HASH |-> byte_q < ent_q.len)
    else $error("hashing past key length");
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == oaht_pkg::F_PUSH && q_full_i |=> state_q == oaht_pkg::F_PUSH && $stable(ent_q))
    else $error("queued entry lost while stalled");

endmodule

[hw/rtl/oaht_queue.sv]
// Two-entry queue between front and back parts.
// Carries oaht_pkg::qent_t; uses oaht_pkg.
module oaht_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enq_i,
  input  oaht_pkg::qent_t enq_data_i,
  output logic            full_o,
  input  logic            deq_i,
  output oaht_pkg::qent_t deq_data_o,
  output logic            empty_o
);

  oaht_pkg::qent_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign deq_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq_i) begin
        wr_q <= ~wr_q;
      end
      if (deq_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, enq_i} - {1'b0, deq_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      mem_q[wr_q] <= enq_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_i |-> !full_o)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> !empty_o)
    else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("queue count corrupt");

endmodule

[hw/rtl/oaht_back.sv]
// Back part: slot memory, clearing sweep and triangular probe sequencer.
// Holds one finished result in an output register. Uses oaht_pkg.
module oaht_back #(
  parameter int unsigned SLOTS     = 1024,
  parameter int unsigned KEY_CHARS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [oaht_pkg::SIZE_W-1:0] size_i,
  input  oaht_pkg::qent_t             q_data_i,
  input  logic                        q_empty_i,
  output logic                        deq_o,
  output oaht_pkg::out_t              out_o,
  output logic                        empty_o,
  input  logic                        pop_i
);

  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KW     = KEY_CHARS * 8;
  localparam int unsigned EW     = oaht_pkg::LEN_W + KW;

  oaht_pkg::back_state_e state_q, state_d;
  oaht_pkg::qent_t       ent_q, ent_d;
  logic [oaht_pkg::SIZE_W-1:0] slot_q, slot_d, probe_q, probe_d;
  logic [ADDR_W-1:0]     clr_q, clr_d;
  logic                  clr_rep_q, clr_rep_d;
  oaht_pkg::out_t        res_q, res_d, out_q;
  logic                  out_valid_q;
  logic                  out_load;

  logic [EW-1:0]         mem_q [SLOTS];
  logic [EW-1:0]         rdata_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [EW-1:0]         mem_wdata;

  logic [oaht_pkg::LEN_W-1:0] rd_len;
  logic                  slot_empty, key_hit, last_probe, is_insert;
  logic [oaht_pkg::SIZE_W:0] nxt_sum;
  logic [oaht_pkg::SIZE_W-1:0] probe_inc;

  assign rd_len     = rdata_q[EW-1 -: oaht_pkg::LEN_W];
  assign slot_empty = (rd_len == '0);
  assign key_hit    = !slot_empty && (rd_len == ent_q.len) &&
                      (rdata_q[KW-1:0] == ent_q.key[KW-1:0]);
  assign last_probe = (probe_q == size_i - oaht_pkg::SIZE_W'(1));
  assign is_insert  = (ent_q.cmd == oaht_pkg::CMD_INSERT);
  assign probe_inc  = probe_q + oaht_pkg::SIZE_W'(1);

  // slot(i+1) = slot(i) + i + 1, both terms below size
  always_comb begin
    nxt_sum = {1'b0, slot_q} + {1'b0, probe_inc};
    if (nxt_sum >= {1'b0, size_i}) begin
      nxt_sum = nxt_sum - {1'b0, size_i};
    end
  end

  // next state
  always_comb begin
    state_d   = state_q;
    ent_d     = ent_q;
    slot_d    = slot_q;
    probe_d   = probe_q;
    clr_d     = clr_q;
    clr_rep_d = clr_rep_q;
    res_d     = res_q;
    case (state_q)
      oaht_pkg::B_CLEAR: begin
        if (clr_q == ADDR_W'(SLOTS - 1)) begin
          clr_rep_d = 1'b0;
          if (clr_rep_q) begin
            res_d   = '{status: oaht_pkg::ST_CLEARED, slot_index: '0, probe_count: '0};
            state_d = oaht_pkg::B_EMIT;
          end else begin
            state_d = oaht_pkg::B_IDLE;
          end
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      oaht_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          ent_d   = q_data_i;
          slot_d  = q_data_i.home;
          probe_d = '0;
          if (q_data_i.cmd == oaht_pkg::CMD_CLEAR) begin
            clr_d     = '0;
            clr_rep_d = 1'b1;
            state_d   = oaht_pkg::B_CLEAR;
          end else if (q_data_i.cmd == oaht_pkg::CMD_LOOKUP && q_data_i.len == '0) begin
            res_d   = '{status: oaht_pkg::ST_NOT_FOUND, slot_index: '0, probe_count: '0};
            state_d = oaht_pkg::B_EMIT;
          end else begin
            state_d = oaht_pkg::B_READ;
          end
        end
      end
      oaht_pkg::B_READ: begin
        state_d = oaht_pkg::B_CHECK;
      end
      oaht_pkg::B_CHECK: begin
        state_d = oaht_pkg::B_EMIT;
        if (slot_empty) begin
          res_d = is_insert ?
                  oaht_pkg::out_t'{status: oaht_pkg::ST_INSERTED, slot_index: 10'(slot_q),
                                   probe_count: 10'(probe_q)} :
                  oaht_pkg::out_t'{status: oaht_pkg::ST_NOT_FOUND, slot_index: '0,
                                   probe_count: '0};
        end else if (key_hit) begin
          res_d = '{status: is_insert ? oaht_pkg::ST_PRESENT : oaht_pkg::ST_FOUND,
                    slot_index: 10'(slot_q), probe_count: 10'(probe_q)};
        end else if (last_probe) begin
          res_d = '{status: is_insert ? oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND,
                    slot_index: '0, probe_count: '0};
        end else begin
          slot_d  = nxt_sum[oaht_pkg::SIZE_W-1:0];
          probe_d = probe_inc;
          state_d = oaht_pkg::B_READ;
        end
      end
      oaht_pkg::B_EMIT: begin
        if (!out_valid_q || pop_i) begin
          state_d = oaht_pkg::B_IDLE;
        end
      end
      default: state_d = oaht_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    deq_o     = (state_q == oaht_pkg::B_IDLE) && !q_empty_i;
    out_load  = (state_q == oaht_pkg::B_EMIT) && (!out_valid_q || pop_i);
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    if (state_q == oaht_pkg::B_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == oaht_pkg::B_CHECK && is_insert && slot_empty &&
                 ent_q.len != '0) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(slot_q);
      mem_wdata = {ent_q.len, ent_q.key[KW-1:0]};
    end
    out_o   = out_q;
    empty_o = !out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaht_pkg::B_CLEAR;
      clr_q       <= '0;
      clr_rep_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_rep_q <= clr_rep_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    slot_q  <= slot_d;
    probe_q <= probe_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == oaht_pkg::B_READ) begin
      rdata_q <= mem_q[ADDR_W'(slot_q)];
    end
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == oaht_pkg::B_READ |-> slot_q < size_i && probe_q < size_i)
    else $error("probe outside table");
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == oaht_pkg::B_CLEAR || state_q == oaht_pkg::B_CHECK)
    else $error("slot write outside clear or check");
  a_no_deq_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |=> state_q != oaht_pkg::B_IDLE)
    else $error("dequeued command not started");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_q))
    else $error("waiting result changed");

endmodule

[hw/rtl/open_addressing_hash_table_core.sv]
// Top level of the open addressing hash table: front hasher, queue, back prober.
// Depends on oaht_pkg, oaht_front, oaht_queue, oaht_back.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------
//   command  | in        | push_i / full_o      | in_i  (cmd, key_bytes, len)
//   result   | out       | pop_i / empty_o      | out_o (status, slot, probes)
//   config   | in        | cfg_valid_i/ready_o  | cfg_data_i (table_size)
//
// A keyed command is hashed one bit per cycle through a compare-subtract
// modulo, then probed with a memory read and a compare per probe; a clear
// sweeps all SLOTS entries of the slot memory.
// After reset the back part clears the whole slot memory; commands are
// hashed and queued meanwhile. A held result stalls the back part, and the
// front part too once the queue between them fills.
module open_addressing_hash_table_core #(
  parameter int unsigned SLOTS     = 1024,
  parameter int unsigned KEY_CHARS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  oaht_pkg::in_t               in_i,
  input  logic                        push_i,
  output logic                        full_o,
  output oaht_pkg::out_t              out_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [oaht_pkg::SIZE_W-1:0] cfg_data_i
);

  logic [oaht_pkg::SIZE_W-1:0] table_size_q;
  logic [oaht_pkg::SIZE_W-1:0] size_eff;
  oaht_pkg::qent_t             enq_data, deq_data;
  logic                        enq, deq, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= oaht_pkg::SIZE_W'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      table_size_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (table_size_q == '0) begin
      size_eff = oaht_pkg::SIZE_W'(1);
    end else if ({6'b0, table_size_q} > 17'(SLOTS)) begin
      size_eff = oaht_pkg::SIZE_W'(SLOTS);
    end else begin
      size_eff = table_size_q;
    end
  end

  oaht_front #(
    .KEY_CHARS (KEY_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .size_i     (size_eff),
    .enq_data_o (enq_data),
    .enq_o      (enq),
    .q_full_i   (q_full)
  );

  oaht_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enq_i      (enq),
    .enq_data_i (enq_data),
    .full_o     (q_full),
    .deq_i      (deq),
    .deq_data_o (deq_data),
    .empty_o    (q_empty)
  );

  oaht_back #(
    .SLOTS     (SLOTS),
    .KEY_CHARS (KEY_CHARS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .size_i    (size_eff),
    .q_data_i  (deq_data),
    .q_empty_i (q_empty),
    .deq_o     (deq),
    .out_o     (out_o),
    .empty_o   (empty_o),
    .pop_i     (pop_i)
  );

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_eff != '0)
    else $error("effective size zero");
  a_enq_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq |-> !q_full)
    else $error("enqueue into full queue");
  a_deq_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq |-> !q_empty)
    else $error("dequeue from empty queue");

endmodule
